@@ design/programmable_sound_generator_defines.svh @@
// Assertion macros used by the sound generator top module.
// Depends on nothing; included by files that carry assertions.
`ifndef PROGRAMMABLE_SOUND_GENERATOR_DEFINES_SVH
`define PROGRAMMABLE_SOUND_GENERATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PSG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/psg_pkg.sv @@
// Package for the programmable sound generator: payload types, op codes,
// amplitude table and the envelope step function. No dependencies.
package psg_pkg;

  localparam int MIX_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LATCH = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } psg_op_t;

  localparam logic [3:0] REG_MIXER    = 4'd7;
  localparam logic [3:0] REG_ENV_LO   = 4'd11;
  localparam logic [3:0] REG_ENV_HI   = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;
  localparam logic [3:0] REG_PORT_A   = 4'd14;
  localparam logic [3:0] REG_PORT_B   = 4'd15;
  localparam logic [16:0] NOISE_SEED  = 17'h04000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] bus_data;
    logic [7:0] port_a_in;
    logic [7:0] port_b_in;
  } psg_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  level_a;
    logic [3:0]  level_b;
    logic [3:0]  level_c;
    logic [15:0] mix_sample;
    logic [7:0]  port_a_out;
    logic [7:0]  port_b_out;
  } psg_out_t;

  // Envelope state handed between the core and the step function.
  typedef struct packed {
    logic [3:0] level;
    logic       rising;
  } psg_env_t;

  // Amplitude of each log step in millionths of full scale.
  function automatic logic [19:0] amp_micro(input logic [3:0] idx);
    logic [19:0] v;
    case (idx)
      4'd0: v = 20'd0;       4'd1: v = 20'd7813;    4'd2: v = 20'd11049;
      4'd3: v = 20'd15625;   4'd4: v = 20'd22097;   4'd5: v = 20'd31250;
      4'd6: v = 20'd44194;   4'd7: v = 20'd62500;   4'd8: v = 20'd88388;
      4'd9: v = 20'd125000;  4'd10: v = 20'd176777; 4'd11: v = 20'd250000;
      4'd12: v = 20'd353553; 4'd13: v = 20'd500000; 4'd14: v = 20'd707107;
      default: v = 20'd1000000;
    endcase
    return v;
  endfunction

  // Fixed-point table entry at MB bits; evaluated on constants only.
  function automatic longint amp_fixed(input int mb, input int idx);
    longint full;
    full = (longint'(1) << mb) - 1;
    return (longint'(amp_micro(4'(idx))) * full + 64'd1500000) / 64'd3000000;
  endfunction

  // One envelope step for the given shape register value.
  function automatic psg_env_t env_step(input psg_env_t cur, input logic [7:0] shape);
    psg_env_t n;
    logic hold, alt, att, cont;
    hold = shape[0];
    alt  = shape[1];
    att  = shape[2];
    cont = shape[3];
    n = cur;
    if (cont && hold && alt && (cur.rising != att)) begin
      n = cur;
    end else if (cur.rising) begin
      if (cur.level == 4'hf) begin
        if (!cont) begin
          n.level = 4'h0; n.rising = 1'b0;
        end else if (hold) begin
          if (alt) begin
            n.level = 4'h0; n.rising = 1'b0;
          end
        end else if (alt) begin
          n.rising = 1'b0;
        end else begin
          n.level = 4'h0;
        end
      end else begin
        n.level = cur.level + 4'd1;
      end
    end else begin
      if (cur.level == 4'h0) begin
        if (cont) begin
          if (hold) begin
            if (alt) begin
              n.level = 4'hf; n.rising = 1'b1;
            end
          end else if (alt) begin
            n.rising = 1'b1;
          end else begin
            n.level = 4'hf;
          end
        end
      end else begin
        n.level = cur.level - 4'd1;
      end
    end
    return n;
  endfunction

endpackage

@@ design/psg_mixer.sv @@
// Amplitude table lookup and three-way sum for the sound generator.
// Depends on psg_pkg.
module psg_mixer import psg_pkg::*; #(
  parameter int MIX_BITS = MIX_BITS_DEF
) (
  input  logic [3:0]  lvl_a,
  input  logic [3:0]  lvl_b,
  input  logic [3:0]  lvl_c,
  output logic [15:0] mix
);
  localparam int SH = (MIX_BITS > 16) ? MIX_BITS - 16 : 0;

  logic [MIX_BITS-1:0] amp_tab [16];
  logic [MIX_BITS+1:0] sum;

  // Constant table built at elaboration.
  for (genvar i = 0; i < 16; i++) begin : g_tab
    assign amp_tab[i] = MIX_BITS'(amp_fixed(MIX_BITS, i));
  end

  assign sum = (MIX_BITS+2)'(amp_tab[lvl_a]) + (MIX_BITS+2)'(amp_tab[lvl_b])
             + (MIX_BITS+2)'(amp_tab[lvl_c]);
  assign mix = 16'(sum >> SH);
endmodule

@@ design/programmable_sound_generator.sv @@
// Channel     | Handshake          | Payload
// in          | in_valid/in_stall  | psg_in_t  (op, bus_data, port pins)
// out         | out_valid/out_stall| psg_out_t (read data, levels, mix, ports)
// One item per clock while not stalled: the item is processed in the cycle it
// is accepted and its result sits in the output register the next cycle.
// The output register is the only buffer, so in_stall follows out_stall
// while a result is waiting. Reset is synchronous, active low, and loads
// the register file, counters and noise seed.
module programmable_sound_generator import psg_pkg::*; #(
  parameter int MIX_BITS = MIX_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  psg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output psg_out_t out_data
);
`include "programmable_sound_generator_defines.svh"

  logic [7:0]  regs_r [16];
  logic [7:0]  regs_nxt [16];
  logic [3:0]  addr_r, addr_nxt;
  logic [11:0] tcnt_r [3];
  logic [11:0] tcnt_nxt [3];
  logic [2:0]  tph_r, tph_nxt;
  logic [4:0]  ncnt_r, ncnt_nxt;
  logic        nbit_r, nbit_nxt;
  logic [16:0] nsh_r, nsh_nxt;
  logic [16:0] ecnt_r, ecnt_nxt;
  psg_env_t    env_r, env_nxt;
  logic [1:0]  pin_r, pin_nxt;
  logic [7:0]  drv_r [2];
  logic [7:0]  drv_nxt [2];
  logic [3:0]  lvl_r [3];
  logic [3:0]  lvl_nxt [3];
  logic [15:0] mix_r, mix_nxt;
  logic [7:0]  rd;
  logic [15:0] mix_w;
  logic        out_valid_r;
  psg_out_t    out_r;
  logic        acc;
  logic [16:0] eper;
  logic [4:0]  np;
  logic        nb;
  logic [11:0] tp;
  logic        want;

  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign eper      = {regs_r[REG_ENV_HI], regs_r[REG_ENV_LO], 1'b0};

  psg_mixer #(.MIX_BITS(MIX_BITS)) u_mix (
    .lvl_a(lvl_nxt[0]), .lvl_b(lvl_nxt[1]), .lvl_c(lvl_nxt[2]), .mix(mix_w)
  );

  always_comb begin
    regs_nxt = regs_r;
    addr_nxt = addr_r;
    tcnt_nxt = tcnt_r;
    tph_nxt  = tph_r;
    ncnt_nxt = ncnt_r;
    nbit_nxt = nbit_r;
    nsh_nxt  = nsh_r;
    ecnt_nxt = ecnt_r;
    env_nxt  = env_r;
    pin_nxt  = pin_r;
    drv_nxt  = drv_r;
    lvl_nxt  = lvl_r;
    mix_nxt  = mix_r;
    rd       = 8'd0;
    np       = regs_r[6][4:0];
    nb       = nbit_r;
    tp       = 12'd0;
    want     = 1'b0;
    if (acc) begin
      case (psg_op_t'(in_data.op))
        OP_TICK: begin
          if (ncnt_r <= 5'd1) begin
            ncnt_nxt = (np == 5'd0) ? 5'd1 : np;
            nsh_nxt  = {nsh_r[0] ^ nsh_r[3], nsh_r[16:1]};
            nb       = nsh_r[1];
            nbit_nxt = nb;
          end else begin
            ncnt_nxt = ncnt_r - 5'd1;
          end
          for (int c = 0; c < 3; c++) begin
            tp = {regs_r[2*c+1][3:0], regs_r[2*c]};
            if (tcnt_r[c] <= 12'd1) begin
              tcnt_nxt[c] = (tp == 12'd0) ? 12'd1 : tp;
              tph_nxt[c]  = !tph_r[c];
            end else begin
              tcnt_nxt[c] = tcnt_r[c] - 12'd1;
            end
            if ((!regs_r[REG_MIXER][c] && tph_nxt[c]) ||
                (!regs_r[REG_MIXER][c+3] && nb)) begin
              lvl_nxt[c] = regs_r[8+c][4] ? env_r.level : regs_r[8+c][3:0];
            end else begin
              lvl_nxt[c] = 4'd0;
            end
          end
          mix_nxt = mix_w;
          if (ecnt_r <= 17'd1) begin
            ecnt_nxt = eper;
            env_nxt  = env_step(env_r, regs_r[REG_ENV_SHAPE]);
          end else begin
            ecnt_nxt = ecnt_r - 17'd1;
          end
        end
        OP_LATCH: addr_nxt = in_data.bus_data[3:0];
        OP_READ: begin
          if (addr_r == REG_PORT_A && pin_r[0]) regs_nxt[14] = in_data.port_a_in;
          if (addr_r == REG_PORT_B && pin_r[1]) regs_nxt[15] = in_data.port_b_in;
          rd = regs_nxt[addr_r];
        end
        default: begin
          regs_nxt[addr_r] = in_data.bus_data;
          if (addr_r == REG_MIXER) begin
            for (int k = 0; k < 2; k++) begin
              want = !in_data.bus_data[6+k];
              if (pin_r[k] != want) begin
                pin_nxt[k] = want;
                if (want) begin
                  drv_nxt[k] = 8'hff;
                end else begin
                  regs_nxt[14+k] = (k == 1) ? in_data.port_b_in : in_data.port_a_in;
                  drv_nxt[k] = regs_nxt[14+k];
                end
              end
            end
          end else if (addr_r == REG_ENV_SHAPE) begin
            env_nxt.rising = in_data.bus_data[2];
            env_nxt.level  = in_data.bus_data[2] ? 4'h0 : 4'hf;
            ecnt_nxt       = eper;
          end else if (addr_r == REG_PORT_A) begin
            drv_nxt[0] = in_data.bus_data;
          end else if (addr_r == REG_PORT_B) begin
            drv_nxt[1] = in_data.bus_data;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) regs_r[i] <= 8'd0;
      addr_r <= 4'd0;
      for (int c = 0; c < 3; c++) begin
        tcnt_r[c] <= 12'd1;
        lvl_r[c]  <= 4'd0;
      end
      tph_r  <= 3'd0;
      ncnt_r <= 5'd1;
      nbit_r <= 1'b0;
      nsh_r  <= NOISE_SEED;
      ecnt_r <= 17'd0;
      env_r  <= '0;
      pin_r  <= 2'b00;
      drv_r[0] <= 8'hff;
      drv_r[1] <= 8'hff;
      mix_r  <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      regs_r <= regs_nxt;
      addr_r <= addr_nxt;
      tcnt_r <= tcnt_nxt;
      tph_r  <= tph_nxt;
      ncnt_r <= ncnt_nxt;
      nbit_r <= nbit_nxt;
      nsh_r  <= nsh_nxt;
      ecnt_r <= ecnt_nxt;
      env_r  <= env_nxt;
      pin_r  <= pin_nxt;
      drv_r  <= drv_nxt;
      lvl_r  <= lvl_nxt;
      mix_r  <= mix_nxt;
      if (acc) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_r.read_data  <= rd;
      out_r.level_a    <= lvl_nxt[0];
      out_r.level_b    <= lvl_nxt[1];
      out_r.level_c    <= lvl_nxt[2];
      out_r.mix_sample <= mix_nxt;
      out_r.port_a_out <= pin_nxt[0] ? 8'hff : drv_nxt[0];
      out_r.port_b_out <= pin_nxt[1] ? 8'hff : drv_nxt[1];
    end
  end

  `PSG_ASSERT_NEXT(a_acc_valid, acc, out_valid, "accepted item produced no result")
  `PSG_ASSERT_IMPL(a_noise_nz, 1'b1, nsh_r != 17'd0, "noise shift register locked at zero")
  `PSG_ASSERT_IMPL(a_ncnt_nz, 1'b1, ncnt_r != 5'd0, "noise counter reached zero")
  `PSG_ASSERT_NEXT(a_hold_out, out_valid && out_stall, $stable(out_data),
                   "result changed while stalled")
endmodule
